// File: src/gww_pkg.sv
// shared types, constants and helpers for the greedy word wrap block
package gww_pkg;

    // field and state widths
    localparam int CHAR_W       = 8;
    localparam int WIDTH_W      = 12;
    localparam int LINE_W       = 13;
    localparam int MAX_WORD_DEF = 32;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd80;
    localparam logic [CHAR_W-1:0]  CHAR_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0]  CHAR_SP     = 8'h20;
    localparam logic [CHAR_W-1:0]  CHAR_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0]  CHAR_CR     = 8'h0D;

    // which byte goes into the output register
    typedef enum logic [1:0] {
        EMIT_NL    = 2'd0,
        EMIT_WORD  = 2'd1,
        EMIT_SPACE = 2'd2,
        EMIT_FINAL = 2'd3
    } emit_kind_t;

    // controller to datapath
    typedef struct packed {
        logic       acc_char;
        logic       acc_flush;
        logic       acc_eoi;
        logic       emit;
        emit_kind_t emit_kind;
        logic       emit_last;
        logic       advance;
        logic       done_word;
    } gww_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_space;
        logic word_empty;
        logic wrap;
        logic idx_last;
        logic out_free;
    } gww_status_t;

    // word separator: space or 0x09..0x0D
    function automatic logic is_white(input logic [CHAR_W-1:0] ch);
        return (ch == CHAR_SP) || ((ch >= CHAR_TAB) && (ch <= CHAR_CR));
    endfunction

endpackage

// File: src/gww_ctrl.sv
// sequencing state machine for the word wrap block
module gww_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 end_of_input,
    output logic                 in_ready,
    input  gww_pkg::gww_status_t status,
    output gww_pkg::gww_cmd_t    cmd
);
    import gww_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_NL    = 5'b00010,
        S_WORD  = 5'b00100,
        S_SPACE = 5'b01000,
        S_FINAL = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   eoi_reg, eoi_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            eoi_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            eoi_reg   <= eoi_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        eoi_next      = eoi_reg;
        cmd           = '0;
        cmd.emit_kind = EMIT_NL;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (end_of_input)
                    begin
                        cmd.acc_flush = 1'b1;
                        cmd.acc_eoi   = 1'b1;
                        eoi_next      = 1'b1;
                        if (status.word_empty)
                            state_next = S_FINAL;
                        else if (status.wrap)
                            state_next = S_NL;
                        else
                            state_next = S_WORD;
                    end
                    else if (status.is_space)
                    begin
                        if (!status.word_empty)
                        begin
                            cmd.acc_flush = 1'b1;
                            eoi_next      = 1'b0;
                            state_next    = status.wrap ? S_NL : S_WORD;
                        end
                    end
                    else
                    begin
                        cmd.acc_char = 1'b1;
                    end
                end
            end
            S_NL:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_NL;
                    state_next    = S_WORD;
                end
            end
            S_WORD:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_WORD;
                    if (status.idx_last)
                        state_next = S_SPACE;
                    else
                        cmd.advance = 1'b1;
                end
            end
            S_SPACE:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_SPACE;
                    cmd.emit_last = !eoi_reg;
                    cmd.done_word = 1'b1;
                    state_next    = eoi_reg ? S_FINAL : S_IDLE;
                end
            end
            S_FINAL:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_FINAL;
                    cmd.emit_last = 1'b1;
                    eoi_next      = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/gww_datapath.sv
// word buffer, length counters, width register and output register
module gww_datapath #(
    parameter int MAX_WORD = gww_pkg::MAX_WORD_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [gww_pkg::CHAR_W-1:0]  in_char,
    input  logic                        cfg_valid,
    input  logic [gww_pkg::WIDTH_W-1:0] line_width,
    input  gww_pkg::gww_cmd_t           cmd,
    output gww_pkg::gww_status_t        status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gww_pkg::CHAR_W-1:0]  out_char,
    output logic                        run_last,
    output logic                        truncated
);
    import gww_pkg::*;

    localparam int LW = $clog2(MAX_WORD + 1);
    localparam int IW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam logic [LW-1:0] WORD_FULL = LW'(MAX_WORD);

    logic [CHAR_W-1:0]  mem [MAX_WORD];
    logic [CHAR_W-1:0]  rd_data_reg;
    logic [IW-1:0]      rd_addr;

    logic [WIDTH_W-1:0] width_reg;
    logic [LW-1:0]      wl_reg, wl_next;
    logic               ovf_reg, ovf_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [LINE_W-1:0]  ll_reg, ll_next;
    logic [LINE_W-1:0]  ll_sum;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;
    logic               out_trunc_reg;
    logic               out_free;
    logic               word_full;

    assign word_full = (wl_reg == WORD_FULL);
    assign out_free  = !out_valid_reg || out_ready;
    assign ll_sum    = ll_reg + LINE_W'(wl_reg);

    // status toward the controller
    always_comb
    begin
        status.is_space   = is_white(in_char);
        status.word_empty = (wl_reg == '0);
        status.wrap       = (ll_sum > LINE_W'(width_reg));
        status.idx_last   = ((LW'(idx_reg) + LW'(1)) == wl_reg);
        status.out_free   = out_free;
    end

    // read address runs one step ahead of the emitted byte
    always_comb
    begin
        if (cmd.acc_flush)
            rd_addr = '0;
        else if (cmd.advance)
            rd_addr = idx_reg + IW'(1);
        else
            rd_addr = idx_reg;
    end

    // word buffer with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.acc_char && !word_full)
            mem[wl_reg[IW-1:0]] <= in_char;
        rd_data_reg <= mem[rd_addr];
    end

    // word, index and line length bookkeeping
    always_comb
    begin
        wl_next  = wl_reg;
        ovf_next = ovf_reg;
        idx_next = idx_reg;
        ll_next  = ll_reg;
        if (cmd.acc_char)
        begin
            if (word_full)
                ovf_next = 1'b1;
            else
                wl_next = wl_reg + LW'(1);
        end
        if (cmd.acc_flush)
        begin
            idx_next = '0;
            if (cmd.acc_eoi)
                ll_next = '0;
            else if (status.wrap)
                ll_next = LINE_W'(wl_reg) + LINE_W'(1);
            else
                ll_next = ll_sum + LINE_W'(1);
        end
        if (cmd.advance)
            idx_next = idx_reg + IW'(1);
        if (cmd.done_word)
        begin
            wl_next  = '0;
            ovf_next = 1'b0;
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            wl_reg    <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            ll_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
                width_reg <= line_width;
            wl_reg  <= wl_next;
            ovf_reg <= ovf_next;
            idx_reg <= idx_next;
            ll_reg  <= ll_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_last_reg  <= cmd.emit_last;
            out_trunc_reg <= (cmd.emit_kind == EMIT_FINAL) ? 1'b0 : ovf_reg;
            case (cmd.emit_kind)
                EMIT_WORD:  out_char_reg <= rd_data_reg;
                EMIT_SPACE: out_char_reg <= CHAR_SP;
                default:    out_char_reg <= CHAR_NL;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign run_last  = out_last_reg;
    assign truncated = out_trunc_reg;

endmodule

// File: src/greedy_word_wrap_core.sv
// greedy word wrap top level: controller plus datapath
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_char[7:0], end_of_input
//  out      output     out_valid / out_ready  out_char[7:0], run_last, truncated
//  cfg      input      cfg_valid / cfg_ready  line_width[11:0]
//
// a word byte is taken and stored in the word buffer while it has room
// whitespace or end of input that closes an n-byte word gives n+1 results
// (n+2 on a wrap, one more for end of input), one per cycle, unless stalled,
// through the output register; the buffer read starts at the accepting edge
// input is taken only while no word is being sent out
// reset clears counters, line length and sets line_width to 80
// a stalled output holds its item and freezes the sequencer
module greedy_word_wrap_core #(
    parameter int MAX_WORD = gww_pkg::MAX_WORD_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gww_pkg::CHAR_W-1:0]  in_char,
    input  logic                        end_of_input,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gww_pkg::CHAR_W-1:0]  out_char,
    output logic                        run_last,
    output logic                        truncated,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gww_pkg::WIDTH_W-1:0] line_width
);
    import gww_pkg::*;

    gww_cmd_t    cmd;
    gww_status_t status;

    assign cfg_ready = 1'b1;

    gww_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .end_of_input (end_of_input),
        .in_ready     (in_ready),
        .status       (status),
        .cmd          (cmd)
    );

    gww_datapath #(
        .MAX_WORD (MAX_WORD)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_char    (in_char),
        .cfg_valid  (cfg_valid),
        .line_width (line_width),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .run_last   (run_last),
        .truncated  (truncated)
    );

endmodule

// File: src/gww_checker.sv
// port level checks for the word wrap block, bound to the top level
module gww_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       end_of_input,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       run_last,
    input logic       truncated
);

    // stalled output item stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    // stalled output payload stays
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_char) && $stable(run_last)
            && $stable(truncated))
        else $error("output payload changed while stalled");

    // end of input always starts a flush, so no input next cycle
    a_eoi_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_input |=> !in_ready)
        else $error("input taken right after end of input");

    // while more results of an item are pending, input is held off
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> !in_ready)
        else $error("input ready in the middle of a result run");

endmodule

bind greedy_word_wrap_core gww_checker u_gww_checker (.*);
